/* rtl/core/pket_pkg.sv */
// Package: shared types and constants of the per-key latency average table.
package pket_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 12;
    localparam int KEY_W       = 22;
    localparam int LAT_W       = 48;
    localparam int AVG_W       = 64;
    localparam int CNT32_W     = 32;
    localparam int ALPHA_W     = 17;
    localparam int MIN_W       = 8;
    localparam int CFG_DATA_W  = 48;
    localparam int FRAC_W      = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RST   = 17'd19661;
    localparam logic [LAT_W-1:0]   WARN_RST    = 48'd2000000;
    localparam logic [LAT_W-1:0]   DANGER_RST  = 48'd5000000;
    localparam logic [MIN_W-1:0]   MIN_RST     = 8'd3;

    localparam logic [1:0] SEV_INFO   = 2'd0;
    localparam logic [1:0] SEV_WARN   = 2'd1;
    localparam logic [1:0] SEV_DANGER = 2'd2;

    localparam logic ST_UPDATED = 1'b0;
    localparam logic ST_FULL    = 1'b1;

    typedef enum logic [1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_WARN   = 2'd1,
        CFG_DANGER = 2'd2,
        CFG_MIN    = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_BLEND,
        S_WAIT,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] process_id;
        logic [LAT_W-1:0] sample_ns;
    } t_in;

    typedef struct packed {
        logic               status;
        logic [SLOT_W-1:0]  slot_index;
        logic [AVG_W-1:0]   average_fixed;
        logic [LAT_W-1:0]   worst_latency_ns;
        logic [CNT32_W-1:0] alert_total;
        logic [1:0]         severity;
        logic               hang_predicted;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [AVG_W-1:0]   avg;
        logic [LAT_W-1:0]   worst;
        logic [CNT32_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* rtl/core/pket_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pket_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pket_blend.sv */
// Moving-average blend unit: one 17x32 multiply per cycle over four partial products.
module pket_blend (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pket_pkg::AVG_W-1:0]      i_avg,
    input  logic [pket_pkg::LAT_W-1:0]      i_lat,
    input  logic [pket_pkg::ALPHA_W-1:0]    i_alpha,
    output logic                            o_done,
    output logic [pket_pkg::AVG_W-1:0]      o_avg
);
    import pket_pkg::*;

    localparam logic [1:0] MS_AVG_HI = 2'd0;
    localparam logic [1:0] MS_AVG_LO = 2'd1;
    localparam logic [1:0] MS_LAT_LO = 2'd2;
    localparam logic [1:0] MS_LAT_HI = 2'd3;
    localparam int PROD_W = ALPHA_W + 32;

    logic                r_busy;
    logic [1:0]          r_step;
    logic                r_pvld;
    logic [1:0]          r_pstep;
    logic [PROD_W-1:0]   r_prod;
    logic [AVG_W-1:0]    r_acc;
    logic                r_done;
    logic [AVG_W-1:0]    r_avg;
    logic [LAT_W-1:0]    r_lat;
    logic [ALPHA_W-1:0]  r_a;
    logic [ALPHA_W-1:0]  r_b;

    logic [ALPHA_W-1:0]  a_clamp;
    logic [ALPHA_W-1:0]  mul_k;
    logic [31:0]         mul_x;
    logic [AVG_W-1:0]    prod_sh;

    assign a_clamp = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;

    always_comb begin
        mul_k = r_a;
        mul_x = 32'(r_lat);
        case (r_step)
            MS_AVG_HI: begin
                mul_k = r_b;
                mul_x = r_avg[63:32];
            end
            MS_AVG_LO: begin
                mul_k = r_b;
                mul_x = r_avg[31:0];
            end
            MS_LAT_LO: begin
                mul_k = r_a;
                mul_x = r_lat[31:0];
            end
            MS_LAT_HI: begin
                mul_k = r_a;
                mul_x = {16'd0, r_lat[47:32]};
            end
            default: begin
                mul_k = r_a;
                mul_x = 32'd0;
            end
        endcase
    end

    always_comb begin
        case (r_pstep)
            MS_AVG_HI: prod_sh = AVG_W'(r_prod) << FRAC_W;
            MS_AVG_LO: prod_sh = AVG_W'(r_prod >> FRAC_W);
            MS_LAT_LO: prod_sh = AVG_W'(r_prod);
            MS_LAT_HI: prod_sh = AVG_W'(r_prod) << 32;
            default:   prod_sh = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= MS_AVG_HI;
            r_pvld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_pvld <= r_busy;
            if (i_start) begin
                if (i_avg == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= MS_AVG_HI;
                end
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == MS_LAT_HI) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_pvld && r_pstep == MS_LAT_HI) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_avg <= i_avg;
            r_lat <= i_lat;
            r_a   <= a_clamp;
            r_b   <= ALPHA_ONE - a_clamp;
            if (i_avg == '0) begin
                r_acc <= AVG_W'(i_lat) << FRAC_W;
            end else begin
                r_acc <= '0;
            end
        end else if (r_pvld) begin
            r_acc <= r_acc + prod_sh;
        end
        r_prod  <= PROD_W'(mul_k) * PROD_W'(mul_x);
        r_pstep <= r_step;
    end

    assign o_done = r_done;
    assign o_avg  = r_acc;

endmodule

/* rtl/core/per_key_latency_ema_tracker_core.sv */
// Top level: per-key latency moving-average table with lookup, claim and update.
//
// One item at a time. For an item accepted while the table holds N claimed slots,
// the key memory is scanned one slot per cycle through its registered read port
// (all N slots on a miss, fewer on an early hit), then the blend unit works through
// its four partial products, and the write state puts the slot back. A miss on a
// full table (4096 slots) drops the item; a dropped item reports in the cycle after
// the scan ends. Claimed slots are always the lowest ones, so a fill count stands in
// for per-slot valid bits and no clearing pass runs after reset. The result beat
// appears on o_result for exactly one cycle with o_result_valid and cannot be held
// off; busy is low again in that cycle.
module per_key_latency_ema_tracker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pket_pkg::t_in                     i_item,
    output logic                              o_result_valid,
    output pket_pkg::t_out                    o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  pket_pkg::t_cfg_reg                i_cfg_index,
    input  logic [pket_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pket_pkg::*;

    t_state              r_state;
    t_state              n_state;

    logic [ALPHA_W-1:0]  r_alpha;
    logic [LAT_W-1:0]    r_warn;
    logic [LAT_W-1:0]    r_danger;
    logic [MIN_W-1:0]    r_min;

    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    r_idx;
    logic                r_cmp_vld;
    logic [ADDR_W-1:0]   r_cmp_idx;
    logic [KEY_W-1:0]    r_key;
    logic [LAT_W-1:0]    r_lat;
    logic [ADDR_W-1:0]   r_slot;
    logic                r_new;
    t_entry              r_entry;
    logic                r_res_vld;
    t_out                r_res;

    logic                issue;
    logic                hit;
    logic                scan_done;
    logic                tbl_full;
    logic                accept;
    logic                blend_start;
    logic                blend_done;
    logic [AVG_W-1:0]    blend_avg;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    t_entry              wr_entry;
    logic                ram_we;

    logic [CNT32_W-1:0]  cnt_new;
    logic [LAT_W-1:0]    worst_new;
    logic                is_danger;
    logic                is_warn;

    assign accept    = start && (r_state == S_IDLE);
    assign issue     = (r_state == S_SCAN) && (r_idx < r_fill);
    assign rd_entry  = t_entry'(ram_rdata);
    assign hit       = r_cmp_vld && (rd_entry.key == r_key);
    assign scan_done = !issue && !r_cmp_vld;
    assign tbl_full  = (r_fill == CNT_W'(TABLE_DEPTH));

    assign cnt_new   = (r_entry.count == '1) ? r_entry.count : r_entry.count + 32'd1;
    assign worst_new = (r_lat > r_entry.worst) ? r_lat : r_entry.worst;
    assign is_danger = blend_avg > {r_danger, 16'd0};
    assign is_warn   = blend_avg > {r_warn, 16'd0};

    assign wr_entry.key   = r_entry.key;
    assign wr_entry.avg   = blend_avg;
    assign wr_entry.worst = worst_new;
    assign wr_entry.count = cnt_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        blend_start = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = S_BLEND;
                end else if (scan_done) begin
                    n_state = tbl_full ? S_IDLE : S_BLEND;
                end
            end
            S_BLEND: begin
                blend_start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (blend_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= ALPHA_RST;
            r_warn   <= WARN_RST;
            r_danger <= DANGER_RST;
            r_min    <= MIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA:  r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                CFG_WARN:   r_warn   <= i_cfg_data[LAT_W-1:0];
                CFG_DANGER: r_danger <= i_cfg_data[LAT_W-1:0];
                CFG_MIN:    r_min    <= i_cfg_data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            if (accept) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_idx     <= r_idx + CNT_W'(issue);
                r_cmp_vld <= issue;
                if (scan_done && !hit && tbl_full) begin
                    r_res_vld <= 1'b1;
                end
            end
            if (r_state == S_WRITE) begin
                r_res_vld <= 1'b1;
                if (r_new) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_item.process_id;
            r_lat <= i_item.sample_ns;
        end
        if (r_state == S_SCAN) begin
            r_cmp_idx <= r_idx[ADDR_W-1:0];
            if (hit) begin
                r_slot  <= r_cmp_idx;
                r_entry <= rd_entry;
                r_new   <= 1'b0;
            end else if (scan_done) begin
                r_slot  <= r_fill[ADDR_W-1:0];
                r_entry <= {r_key, {(ENTRY_W - KEY_W){1'b0}}};
                r_new   <= 1'b1;
                r_res   <= {ST_FULL, {($bits(t_out) - 1){1'b0}}};
            end
        end
        if (r_state == S_WRITE) begin
            r_res <= {ST_UPDATED, SLOT_W'(r_slot), blend_avg, worst_new, cnt_new,
                      is_danger ? SEV_DANGER : (is_warn ? SEV_WARN : SEV_INFO),
                      is_danger && (cnt_new >= CNT32_W'(r_min))};
        end
    end

    pket_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ENTRY_W'(wr_entry)),
        .i_re    (issue),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    pket_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (blend_start),
        .i_avg   (r_entry.avg),
        .i_lat   (r_lat),
        .i_alpha (r_alpha),
        .o_done  (blend_done),
        .o_avg   (blend_avg)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;
    assign o_cfg_ready    = 1'b1;

endmodule

/* rtl/core/pket_checker.sv */
// Port-level checker for the latency average table, bound to the top level.
module pket_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             o_result_valid,
    input  pket_pkg::t_out   o_result
);
    import pket_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted beat");

    a_result_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy && $past(busy))
        else $error("result beat outside end of work");

    a_drop_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == ST_FULL |->
            o_result.slot_index == '0 && o_result.average_fixed == '0 &&
            o_result.alert_total == '0 && o_result.hang_predicted == 1'b0)
        else $error("dropped beat carries data");

    a_predict_danger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.hang_predicted |-> o_result.severity == SEV_DANGER)
        else $error("prediction without danger level");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == ST_UPDATED |-> o_result.alert_total != '0)
        else $error("updated slot with zero count");

endmodule

bind per_key_latency_ema_tracker_core pket_checker u_pket_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

/* dv/tb_per_key_latency_ema_tracker_core.sv */
// Testbench for the per-key latency moving-average table: directed rows and random traffic.
`timescale 1ns / 100ps

module tb_per_key_latency_ema_tracker_core;
    import pket_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in                i_item;
    logic               o_result_valid;
    t_out               o_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_reg           i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    per_key_latency_ema_tracker_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    typedef struct {
        bit                    is_reg;
        t_cfg_reg              reg_sel;
        logic [CFG_DATA_W-1:0] value;
        t_in                   item;
        bit                    known;
        t_out                  want;
    } t_step;

    // predictor state: slots are claimed lowest first and never freed
    int                 slot_of [bit [KEY_W-1:0]];
    int                 slots_used;
    logic [AVG_W-1:0]   avg_tab   [TABLE_DEPTH];
    logic [LAT_W-1:0]   worst_tab [TABLE_DEPTH];
    logic [CNT32_W-1:0] total_tab [TABLE_DEPTH];
    logic [ALPHA_W-1:0] alpha_cfg  = ALPHA_RST;
    logic [LAT_W-1:0]   warn_cfg   = WARN_RST;
    logic [LAT_W-1:0]   danger_cfg = DANGER_RST;
    logic [MIN_W-1:0]   min_cfg    = MIN_RST;

    t_out               expected_q [$];
    t_out               front_beat;
    int                 error_count;
    int                 beats_checked;
    int                 items_sent;
    int                 full_drops;
    int                 reg_writes;
    int                 idle_pct;
    logic [KEY_W-1:0]   key_pool [16];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_out track_latency(input t_in it);
        t_out             r;
        int               s;
        logic [63:0]      a;
        logic [63:0]      b;
        logic [AVG_W-1:0] avg;
        logic             danger;
        r = '0;
        if (slot_of.exists(it.process_id)) begin
            s = slot_of[it.process_id];
        end else if (slots_used == TABLE_DEPTH) begin
            r.status = ST_FULL;
            full_drops++;
            return r;
        end else begin
            s = slots_used;
            slots_used++;
            slot_of[it.process_id] = s;
            avg_tab[s]   = '0;
            worst_tab[s] = '0;
            total_tab[s] = '0;
        end
        if (total_tab[s] != '1)
            total_tab[s] = total_tab[s] + 1;
        if (it.sample_ns > worst_tab[s])
            worst_tab[s] = it.sample_ns;
        avg = avg_tab[s];
        if (avg == '0) begin
            avg = {it.sample_ns, 16'h0};
        end else begin
            a   = (alpha_cfg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_cfg);
            b   = 64'd65536 - a;
            avg = a * 64'(it.sample_ns) + ((b * (avg >> 32)) << 16)
                + ((b * (avg & 64'hFFFF_FFFF)) >> 16);
        end
        avg_tab[s] = avg;
        danger = avg > {danger_cfg, 16'h0};
        r.status           = ST_UPDATED;
        r.slot_index       = s[SLOT_W-1:0];
        r.average_fixed    = avg;
        r.worst_latency_ns = worst_tab[s];
        r.alert_total      = total_tab[s];
        r.severity         = danger ? SEV_DANGER :
                             (avg > {warn_cfg, 16'h0}) ? SEV_WARN : SEV_INFO;
        r.hang_predicted   = danger && (total_tab[s] >= 32'(min_cfg));
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected");
                error_count++;
            end else begin
                front_beat = expected_q.pop_front();
                compare_field("status", 64'(front_beat.status), 64'(o_result.status));
                compare_field("slot_index", 64'(front_beat.slot_index),
                              64'(o_result.slot_index));
                compare_field("average_fixed", front_beat.average_fixed,
                              o_result.average_fixed);
                compare_field("worst_latency_ns", 64'(front_beat.worst_latency_ns),
                              64'(o_result.worst_latency_ns));
                compare_field("alert_total", 64'(front_beat.alert_total),
                              64'(o_result.alert_total));
                compare_field("severity", 64'(front_beat.severity), 64'(o_result.severity));
                compare_field("hang_predicted", 64'(front_beat.hang_predicted),
                              64'(o_result.hang_predicted));
                beats_checked++;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input t_in it, input bit known, input t_out want);
        t_out guess;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        guess = track_latency(it);
        expected_q.push_back(known ? want : guess);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0 || busy)
            @(negedge i_clk);
    endtask

    // leaves valid high; the caller lowers it before the next item
    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            CFG_ALPHA:  alpha_cfg  = value[ALPHA_W-1:0];
            CFG_WARN:   warn_cfg   = value[LAT_W-1:0];
            CFG_DANGER: danger_cfg = value[LAT_W-1:0];
            CFG_MIN:    min_cfg    = value[MIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
    endtask

    function automatic t_step reg_step(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] value);
        t_step st;
        st.is_reg  = 1'b1;
        st.reg_sel = sel;
        st.value   = value;
        st.item    = '0;
        st.known   = 1'b0;
        st.want    = '0;
        return st;
    endfunction

    function automatic t_step item_step(input logic [KEY_W-1:0] id, input logic [LAT_W-1:0] lat);
        t_step st;
        st.is_reg         = 1'b0;
        st.reg_sel        = CFG_ALPHA;
        st.value          = '0;
        st.item.process_id = id;
        st.item.sample_ns  = lat;
        st.known          = 1'b0;
        st.want           = '0;
        return st;
    endfunction

    function automatic t_step known_step(input logic [KEY_W-1:0] id, input logic [LAT_W-1:0] lat,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic [AVG_W-1:0] avg,
                                         input logic [LAT_W-1:0] worst,
                                         input logic [CNT32_W-1:0] total,
                                         input logic [1:0] sev, input logic hang);
        t_step st;
        st = item_step(id, lat);
        st.known                 = 1'b1;
        st.want.status           = ST_UPDATED;
        st.want.slot_index       = slot;
        st.want.average_fixed    = avg;
        st.want.worst_latency_ns = worst;
        st.want.alert_total      = total;
        st.want.severity         = sev;
        st.want.hang_predicted   = hang;
        return st;
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  pick;
        it.process_id = ($urandom_range(99) < 70) ? key_pool[$urandom_range(15)]
                                                   : KEY_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
            it.sample_ns = LAT_W'($urandom_range(0, 10_000_000));
        else if (pick < 70)
            it.sample_ns = LAT_W'($urandom_range(0, 100));
        else if (pick < 85)
            it.sample_ns = LAT_W'({$urandom, $urandom});
        else if (pick < 95)
            it.sample_ns = '1;
        else
            it.sample_ns = '0;
        return it;
    endfunction

    initial begin
        t_step              plan [$];
        t_in                it;
        t_out               none;
        int                 pct [3];

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ALPHA;
        i_cfg_data  = '0;
        idle_pct    = 0;
        none        = '0;
        pct         = '{0, 68, 26};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < 16; k++)
            key_pool[k] = KEY_W'($urandom);

        plan.push_back(known_step(22'd0, 48'd0, 12'd0, 64'd0, 48'd0, 32'd1, SEV_INFO, 1'b0));
        // stored average of zero reseeds
        plan.push_back(known_step(22'd0, 48'd1000, 12'd0, {48'd1000, 16'h0}, 48'd1000, 32'd2,
                                  SEV_INFO, 1'b0));
        plan.push_back(known_step('1, '1, 12'd1, 64'hFFFF_FFFF_FFFF_0000, '1, 32'd1,
                                  SEV_DANGER, 1'b0));
        plan.push_back(known_step('1, '1, 12'd1, 64'hFFFF_FFFF_FFFF_0000, '1, 32'd2,
                                  SEV_DANGER, 1'b0));
        plan.push_back(known_step('1, '1, 12'd1, 64'hFFFF_FFFF_FFFF_0000, '1, 32'd3,
                                  SEV_DANGER, 1'b1));
        // strict threshold edges
        plan.push_back(known_step(22'd5, 48'd2000000, 12'd2, {48'd2000000, 16'h0}, 48'd2000000,
                                  32'd1, SEV_INFO, 1'b0));
        plan.push_back(known_step(22'd6, 48'd2000001, 12'd3, {48'd2000001, 16'h0}, 48'd2000001,
                                  32'd1, SEV_WARN, 1'b0));
        plan.push_back(known_step(22'd7, 48'd5000000, 12'd4, {48'd5000000, 16'h0}, 48'd5000000,
                                  32'd1, SEV_WARN, 1'b0));
        plan.push_back(known_step(22'd8, 48'd5000001, 12'd5, {48'd5000001, 16'h0}, 48'd5000001,
                                  32'd1, SEV_DANGER, 1'b0));
        plan.push_back(reg_step(CFG_MIN, 48'd0));
        plan.push_back(known_step(22'd9, 48'd5000001, 12'd6, {48'd5000001, 16'h0}, 48'd5000001,
                                  32'd1, SEV_DANGER, 1'b1));
        // alpha zero holds the average
        plan.push_back(reg_step(CFG_ALPHA, 48'd0));
        plan.push_back(known_step(22'd5, 48'd123456, 12'd2, {48'd2000000, 16'h0}, 48'd2000000,
                                  32'd2, SEV_INFO, 1'b0));
        // alpha above one acts as one
        plan.push_back(reg_step(CFG_ALPHA, 48'd131071));
        plan.push_back(known_step(22'd5, 48'd7, 12'd2, {48'd7, 16'h0}, 48'd2000000,
                                  32'd3, SEV_INFO, 1'b0));
        plan.push_back(reg_step(CFG_ALPHA, 48'(ALPHA_ONE)));
        plan.push_back(known_step(22'd6, 48'd0, 12'd3, 64'd0, 48'd2000001, 32'd2,
                                  SEV_INFO, 1'b0));
        plan.push_back(known_step(22'd6, 48'd3000000, 12'd3, {48'd3000000, 16'h0}, 48'd3000000,
                                  32'd3, SEV_WARN, 1'b0));
        plan.push_back(reg_step(CFG_ALPHA, 48'd1));
        plan.push_back(item_step(22'd7, 48'd0));
        plan.push_back(reg_step(CFG_WARN, 48'd0));
        plan.push_back(reg_step(CFG_DANGER, 48'd0));
        plan.push_back(item_step(22'd0, 48'd1));
        plan.push_back(reg_step(CFG_WARN, '1));
        plan.push_back(reg_step(CFG_DANGER, '1));
        plan.push_back(known_step('1, '1, 12'd1, 64'hFFFF_FFFF_FFFF_0000, '1, 32'd4,
                                  SEV_INFO, 1'b0));
        plan.push_back(reg_step(CFG_ALPHA, 48'(ALPHA_RST)));
        plan.push_back(reg_step(CFG_WARN, WARN_RST));
        plan.push_back(reg_step(CFG_DANGER, DANGER_RST));
        plan.push_back(reg_step(CFG_MIN, 48'd255));
        plan.push_back(item_step(22'd8, 48'd9000000));
        plan.push_back(item_step(22'h2AAAAA, 48'h5555_5555_5555));
        plan.push_back(item_step(22'h155555, 48'hAAAA_AAAA_AAAA));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                drain();
                write_reg(plan[k].reg_sel, plan[k].value);
            end else begin
                i_cfg_valid <= 1'b0;
                send_item(plan[k].item, plan[k].known, plan[k].want);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            idle_pct = pct[ph % 3];
            case ($urandom_range(3))
                0:       write_reg(CFG_ALPHA, 48'd1);
                1:       write_reg(CFG_ALPHA, 48'd131071);
                default: write_reg(CFG_ALPHA, 48'($urandom_range(0, 65536)));
            endcase
            write_reg(CFG_WARN, ($urandom_range(7) == 0) ? '1 :
                                48'($urandom_range(0, 4_000_000)));
            write_reg(CFG_DANGER, ($urandom_range(7) == 0) ? '0 :
                                  48'($urandom_range(0, 8_000_000)));
            write_reg(CFG_MIN, ($urandom_range(5) == 0) ? 48'd255 : 48'($urandom_range(0, 6)));
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < 20; n++) begin
                it = random_item();
                send_item(it, 1'b0, none);
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("Checked %0d result beats from %0d items over directed rows and random phases.",
                 beats_checked, items_sent);
        $display("Register writes: %0d, slots claimed: %0d, dropped: %0d.",
                 reg_writes, slots_used, full_drops);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
